@@ design/kth_ancestor_binary_lifting_macros.svh @@
// Assertion helpers shared by the RTL. Both expect clk_i and rst_ni in scope.
`ifndef KTH_ANCESTOR_BINARY_LIFTING_MACROS_SVH
`define KTH_ANCESTOR_BINARY_LIFTING_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KAB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KAB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/kab_pkg.sv @@
package kab_pkg;

  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned LEVELS    = 11;

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned LVL_W  = $clog2(LEVELS);
  localparam int unsigned ADDR_W = LVL_W + NODE_W;
  localparam int unsigned DEPTH  = LEVELS * MAX_NODES;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned VAL_W  = 11;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned DIST_W = 16;
  localparam int unsigned PW_W   = $clog2(DIST_W + 1);

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [LVL_W-1:0]        lvl_t;
  typedef logic [NODE_W-1:0]       node_t;
  typedef logic [ADDR_W-1:0]       addr_t;

  localparam val_t VAL_NONE = '1;  // -1: no such node
  localparam lvl_t LVL_BASE = '0;  // level holding the loaded parents

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B_RD,
    ST_B_MID,
    ST_B_WR,
    ST_Q_STEP,
    ST_Q_WAIT,
    ST_DONE
  } state_e;

  // Node count as the engine uses it: zero acts as one, anything above
  // the table capacity is clipped.
  function automatic cnt_t eff_count(cnt_t raw);
    cnt_t res;
    if (raw == '0) begin
      res = CNT_W'(1);
    end else if (32'(raw) > MAX_NODES) begin
      res = CNT_W'(MAX_NODES);
    end else begin
      res = raw;
    end
    return res;
  endfunction

  // Smallest L with 2^L above the count, capped at LEVELS.
  function automatic lvl_t level_count(cnt_t cnt);
    lvl_t n;
    n = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if ((32'(1) << l) <= 32'(cnt)) begin
        n = n + LVL_W'(1);
      end
    end
    return n;
  endfunction

  // Entries at or above the count, and negative ones, read as no node.
  function automatic val_t clean(val_t v, cnt_t cnt);
    val_t res;
    if (v[VAL_W-1] || (CNT_W'(unsigned'(v)) >= cnt)) begin
      res = VAL_NONE;
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic addr_t mk_addr(lvl_t lvl, node_t n);
    return {lvl, n};
  endfunction

endpackage

@@ design/kab_in_if.sv @@
interface kab_in_if;
  import kab_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [NODE_W-1:0]        node;
  logic signed [VAL_W-1:0]  parent_value;
  logic [DIST_W-1:0]        distance;

  modport source (output valid, cmd, node, parent_value, distance, input ready);
  modport sink   (input valid, cmd, node, parent_value, distance, output ready);
endinterface

@@ design/kab_out_if.sv @@
interface kab_out_if;
  import kab_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  ancestor;

  modport source (output valid, ancestor, input ready);
  modport sink   (input valid, ancestor, output ready);
endinterface

@@ design/kab_ram.sv @@
module kab_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 11264,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/kth_ancestor_binary_lifting.sv @@
// Binary-lifting k-th ancestor engine. The ancestor table sits in one
// simple dual-port RAM of LEVELS x MAX_NODES entries (one write, one read
// port, registered read data), addressed by {level, node}. A load word
// writes one parent into level 0 and then passes through the done state
// to the output register. A build word fills levels 1 to L-1 entry by
// entry: it reads the level-(j-1) ancestor, writes no node if that is
// missing, and otherwise reads the ancestor's own level-(j-1) entry and
// writes it to level j. A query word walks the distance bit by bit, with
// a dependent RAM read for each set bit, and stops early at the root.
// One word is in flight at a time, but a finished answer waits in the
// output register while the next word is accepted. The table has no
// reset and needs no clearing pass: every entry a build or query reads
// must have been loaded or built first. The user must write node_count
// only while the engine is idle; the block itself does not enforce it.
`include "kth_ancestor_binary_lifting_macros.svh"

module kth_ancestor_binary_lifting (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [kab_pkg::CNT_W-1:0] cfg_wdata_i,
  kab_in_if.sink                req_i,
  kab_out_if.source             rsp_o
);
  import kab_pkg::*;

  state_e state_q, state_d;

  // Configuration, kept already clipped together with the level count.
  cnt_t cnt_q;
  lvl_t lvl_q;

  // Build walk: level j_q, node i_q.
  node_t i_q, i_d;
  lvl_t  j_q, j_d;

  // Query walk: current node, remaining distance, current power of two.
  val_t              cur_q, cur_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [PW_W-1:0]   pw_q, pw_d;

  logic out_valid_q, out_valid_d;
  val_t out_data_q, out_data_d;

  logic  ram_we, ram_re;
  addr_t ram_waddr, ram_raddr;
  val_t  ram_wdata, ram_rdata;

  kab_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cmd_e req_cmd;
  cnt_t cnt_m1;
  lvl_t j_m1;
  val_t mid;
  logic mid_none, last_i, last_j, last_entry, pw_past, q_end, out_free;

  assign req_cmd    = cmd_e'(req_i.cmd);
  assign cnt_m1     = cnt_q - CNT_W'(1);
  assign j_m1       = j_q - LVL_W'(1);
  assign mid        = clean(ram_rdata, cnt_q);
  assign mid_none   = mid[VAL_W-1];
  assign last_i     = (i_q == cnt_m1[NODE_W-1:0]);
  assign last_j     = (j_q == (lvl_q - LVL_W'(1)));
  assign last_entry = last_i && last_j;
  assign pw_past    = (pw_q >= PW_W'(lvl_q));
  assign q_end      = (dist_q == '0) || cur_q[VAL_W-1];
  assign out_free   = !out_valid_q || rsp_o.ready;

  assign req_i.ready    = (state_q == ST_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.ancestor = out_data_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          case (req_cmd)
            CMD_BUILD: state_d = (lvl_q > LVL_W'(1)) ? ST_B_RD : ST_DONE;
            CMD_QUERY: state_d = ST_Q_STEP;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_B_RD: begin
        state_d = ST_B_MID;
      end
      ST_B_MID: begin
        if (!mid_none) begin
          state_d = ST_B_WR;
        end else begin
          state_d = last_entry ? ST_DONE : ST_B_RD;
        end
      end
      ST_B_WR: begin
        state_d = last_entry ? ST_DONE : ST_B_RD;
      end
      ST_Q_STEP: begin
        if (q_end || (dist_q[0] && pw_past)) begin
          state_d = ST_DONE;
        end else if (dist_q[0]) begin
          state_d = ST_Q_WAIT;
        end
      end
      ST_Q_WAIT: begin
        state_d = ST_Q_STEP;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and output register.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = VAL_NONE;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    i_d         = i_q;
    j_d         = j_q;
    cur_d       = cur_q;
    dist_d      = dist_q;
    pw_d        = pw_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          i_d    = '0;
          j_d    = LVL_W'(1);
          cur_d  = '0;
          dist_d = req_i.distance;
          pw_d   = '0;
          case (req_cmd)
            CMD_LOAD: begin
              // An 11-bit parent is always below MAX_NODES when it is not
              // negative, so only the sign marks a root.
              ram_we    = 1'b1;
              ram_waddr = mk_addr(LVL_BASE, req_i.node);
              ram_wdata = req_i.parent_value[VAL_W-1] ? VAL_NONE : req_i.parent_value;
            end
            CMD_QUERY: begin
              cur_d = (CNT_W'(req_i.node) < cnt_q) ? val_t'({1'b0, req_i.node})
                                                  : VAL_NONE;
            end
            default: ;
          endcase
        end
      end
      ST_B_RD: begin
        ram_re    = 1'b1;
        ram_raddr = mk_addr(j_m1, i_q);
      end
      ST_B_MID: begin
        if (mid_none) begin
          ram_we    = 1'b1;
          ram_waddr = mk_addr(j_q, i_q);
          ram_wdata = VAL_NONE;
          if (last_i) begin
            i_d = '0;
            j_d = j_q + LVL_W'(1);
          end else begin
            i_d = i_q + NODE_W'(1);
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = mk_addr(j_m1, mid[NODE_W-1:0]);
        end
      end
      ST_B_WR: begin
        ram_we    = 1'b1;
        ram_waddr = mk_addr(j_q, i_q);
        ram_wdata = ram_rdata;
        if (last_i) begin
          i_d = '0;
          j_d = j_q + LVL_W'(1);
        end else begin
          i_d = i_q + NODE_W'(1);
        end
      end
      ST_Q_STEP: begin
        if (!q_end) begin
          if (dist_q[0]) begin
            if (pw_past) begin
              // The climb needs a level the table does not have.
              cur_d = VAL_NONE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = mk_addr(pw_q[LVL_W-1:0], cur_q[NODE_W-1:0]);
            end
          end
          dist_d = dist_q >> 1;
          pw_d   = pw_q + PW_W'(1);
        end
      end
      ST_Q_WAIT: begin
        cur_d = mid;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = cur_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= CNT_W'(1);
      lvl_q       <= LVL_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cnt_q <= eff_count(cfg_wdata_i);
        lvl_q <= level_count(eff_count(cfg_wdata_i));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    cur_q      <= cur_d;
    dist_q     <= dist_d;
    pw_q       <= pw_d;
    out_data_q <= out_data_d;
  end

  // Build reads level j-1 while writing level j, so the two ports never
  // meet on one entry and no forwarding is needed.
  `KAB_ASSERT_IMP(a_no_same_entry, ram_we && ram_re, ram_waddr != ram_raddr,
                  "table read and write hit the same entry")
  `KAB_ASSERT_IMP(a_query_no_write,
                  (state_q == ST_Q_STEP) || (state_q == ST_Q_WAIT), !ram_we,
                  "table written during a query")
  `KAB_ASSERT_IMP(a_build_not_base, ram_we && (state_q != ST_IDLE),
                  ram_waddr[ADDR_W-1:NODE_W] != LVL_BASE,
                  "build overwrote a loaded parent")
  `KAB_ASSERT_NXT(a_done_delivers, (state_q == ST_DONE) && out_free,
                  out_valid_q && (state_q == ST_IDLE),
                  "finished word not placed in the output register")

endmodule
